>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int POOL_ORDER_MAX_DEF = 20;
   localparam int HEADER_BYTES_DEF   = 24;
   localparam int GRAIN_ORDER        = 5;
   localparam int POOL_ORDER_MIN     = 6;

   localparam int REQ_W = 21;
   localparam int OFF_W = 20;
   localparam int ORD_W = 5;

   typedef enum logic [1:0] {
      TAG_RESERVED = 2'd0,
      TAG_FREE     = 2'd1,
      TAG_UNUSED   = 2'd2
   } tag_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_TOOBIG  = 2'd2,
      ST_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DONE,
      A_SIZE, A_SRCH, A_RM, A_RM_FIX, A_SPLIT, PUSH_FIX,
      F_CHK, F_MERGE, F_BUD, F_RM_P, F_RM_N, F_RM_NF, F_UNU, F_PUSH
   } state_type;

   typedef struct packed {
      status_type       status;
      logic [OFF_W-1:0] offset;
      logic [ORD_W-1:0] order;
   } res_type;

endpackage

>>> hw/rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 2^pool_order byte pool with an APB-style CSR port.
// ----------------------------------------------------------------------------
// One beat in, one beat out. An allocate sizes the request to order k, one
// order per step, searches the free lists one order per step, unlinks the
// head block and fixes the back link of the block after it, if any, splits
// down to order k, pushing each upper half, and then reserves the block. A
// free checks the block's tag, then per merge level reads the buddy,
// unlinks it if it is free at the same order and marks the upper half
// unused, and then pushes the merged block; a rejected free ends after its
// check. All steps use a single table RAM with registered read. After
// reset and after each pool_order write the table is swept, one entry a
// cycle, all 2^(POOL_ORDER_MAX-5) entries; req_stall is high meanwhile. A
// result is held in an output register while the next request is taken.
module buddy_block_allocator import bba_pkg::*; #(
   parameter int POOL_ORDER_MAX = POOL_ORDER_MAX_DEF,
   parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_action,
   input  logic [REQ_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0] req_user_offset,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [OFF_W-1:0] rsp_granted_offset,
   output logic [ORD_W-1:0] rsp_granted_order,
   // CSR port
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [ORD_W-1:0] pool_order_ff, pool_order_in;
   logic [ORD_W:0]   wv;
   logic             cfg_wr;
   logic             res_valid, res_ready;
   res_type          res;
   logic             rsp_valid_ff, rsp_valid_in;
   res_type          rsp_ff, rsp_in;

   // only one register, so every write lands on pool_order
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 || 1'b1);
   assign wv     = {1'b0, pwdata[ORD_W-1:0]};

   always_comb begin
      if (wv < (ORD_W+1)'(POOL_ORDER_MIN))
         pool_order_in = ORD_W'(POOL_ORDER_MIN);
      else if (wv > (ORD_W+1)'(POOL_ORDER_MAX))
         pool_order_in = ORD_W'(POOL_ORDER_MAX);
      else
         pool_order_in = wv[ORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_order_ff <= ORD_W'(POOL_ORDER_MAX);
      end else if (cfg_wr) begin
         pool_order_ff <= pool_order_in;
      end
   end

   assign prdata = 32'(pool_order_ff);

   bba_core #(
      .POOL_ORDER_MAX (POOL_ORDER_MAX),
      .HEADER_BYTES   (HEADER_BYTES)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg_wr            (cfg_wr),
      .cfg_order         (pool_order_in),
      .pool_order        (pool_order_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_request_bytes (req_request_bytes),
      .req_user_offset   (req_user_offset),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_granted_offset = rsp_ff.offset;
   assign rsp_granted_order  = rsp_ff.order;

endmodule

>>> hw/rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bba_heads.sv
// ----------------------------------------------------------------------------
// bba_heads
// Per-order free list head registers, one read and one write per cycle.
// ----------------------------------------------------------------------------
module bba_heads import bba_pkg::*; #(
   parameter int POOL_ORDER_MAX = POOL_ORDER_MAX_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   init,
   input  logic [ORD_W-1:0]                       init_order,
   input  logic [ORD_W-1:0]                       rd_order,
   output logic [POOL_ORDER_MAX-GRAIN_ORDER:0]    rd_value,
   input  logic                                   wr_en,
   input  logic [ORD_W-1:0]                       wr_order,
   input  logic [POOL_ORDER_MAX-GRAIN_ORDER:0]    wr_value
);

   localparam int LNK_W = POOL_ORDER_MAX - GRAIN_ORDER + 1;

   logic [LNK_W-1:0] heads_ff [0:POOL_ORDER_MAX];

   always_ff @(posedge clock) begin
      for (int j = 0; j <= POOL_ORDER_MAX; j++) begin
         if (reset) begin
            heads_ff[j] <= (ORD_W'(j) == ORD_W'(POOL_ORDER_MAX)) ? '0 : '1;
         end else if (init) begin
            heads_ff[j] <= (ORD_W'(j) == init_order) ? '0 : '1;
         end else if (wr_en && wr_order == ORD_W'(j)) begin
            heads_ff[j] <= wr_value;
         end
      end
   end

   always_comb begin
      rd_value = '1;
      for (int j = 0; j <= POOL_ORDER_MAX; j++) begin
         if (rd_order == ORD_W'(j)) begin
            rd_value = heads_ff[j];
         end
      end
   end

endmodule

>>> hw/rtl/bba_core.sv
// ----------------------------------------------------------------------------
// bba_core
// Allocate/free sequencer: walks orders one step a cycle, doing block-table
// read-modify-writes and free list updates.
// ----------------------------------------------------------------------------
module bba_core import bba_pkg::*; #(
   parameter int POOL_ORDER_MAX = POOL_ORDER_MAX_DEF,
   parameter int HEADER_BYTES   = HEADER_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cfg_wr,
   input  logic [ORD_W-1:0] cfg_order,
   input  logic [ORD_W-1:0] pool_order,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_action,
   input  logic [REQ_W-1:0] req_request_bytes,
   input  logic [OFF_W-1:0] req_user_offset,
   output logic             res_valid,
   input  logic             res_ready,
   output res_type          res
);

   localparam int IDX_W   = POOL_ORDER_MAX - GRAIN_ORDER;
   localparam int LNK_W   = IDX_W + 1;
   localparam int ENTRIES = 1 << IDX_W;
   localparam int WORD_W  = 2 + ORD_W + 2 * LNK_W;
   localparam int SZ_W    = ((REQ_W > POOL_ORDER_MAX) ? REQ_W : POOL_ORDER_MAX) + 2;
   localparam int CW      = ((OFF_W > POOL_ORDER_MAX) ? OFF_W : POOL_ORDER_MAX) + 1;
   localparam logic [LNK_W-1:0] NIL = '1;

   function automatic logic [WORD_W-1:0] mk(tag_type t, logic [ORD_W-1:0] o,
                                             logic [LNK_W-1:0] nx, logic [LNK_W-1:0] pv);
      mk = {t, o, nx, pv};
   endfunction

   state_type        state_ff, state_in;
   action_type       op_ff, op_in;
   logic [SZ_W-1:0]  size_ff, size_in;
   logic [ORD_W-1:0] k_ff, k_in, i_ff, i_in;
   logic [IDX_W-1:0] idx_ff, idx_in, bud_ff, bud_in, pend_ff, pend_in, cnt_ff, cnt_in;
   logic [LNK_W-1:0] p_ff, p_in, n_ff, n_in;
   res_type          res_ff, res_in;

   // block table port
   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;
   tag_type           rd_tag;
   logic [ORD_W-1:0]  rd_ord;
   logic [LNK_W-1:0]  rd_nxt, rd_prv;

   // head table port
   logic [ORD_W-1:0] hd_rd_ord, hd_wr_ord;
   logic [LNK_W-1:0] hd_rd_val, hd_wr_val;
   logic             hd_wr_en;

   // shared arithmetic
   logic [CW-1:0]    uoff_c, hdr_c, start_c, off_c;
   logic             f_ok;
   logic [IDX_W-1:0] fidx, split_b, merge_b;
   logic [ORD_W-1:0] ord_m1;
   logic [SZ_W-1:0]  pow;

   assign rd_tag = tag_type'(rd_data[WORD_W-1 -: 2]);
   assign rd_ord = rd_data[2*LNK_W +: ORD_W];
   assign rd_nxt = rd_data[LNK_W +: LNK_W];
   assign rd_prv = rd_data[0 +: LNK_W];

   assign uoff_c  = CW'(req_user_offset);
   assign hdr_c   = CW'(HEADER_BYTES);
   assign start_c = uoff_c - hdr_c;
   assign f_ok    = (uoff_c >= hdr_c) && (start_c[GRAIN_ORDER-1:0] == '0) &&
                    (start_c < (CW'(1) << pool_order));
   assign fidx    = start_c[GRAIN_ORDER +: IDX_W];
   assign off_c   = (CW'(idx_ff) << GRAIN_ORDER) + hdr_c;
   assign ord_m1  = i_ff - ORD_W'(1);
   assign split_b = idx_ff ^ (IDX_W'(1) << (ord_m1 - ORD_W'(GRAIN_ORDER)));
   assign merge_b = idx_ff ^ (IDX_W'(1) << (k_ff - ORD_W'(GRAIN_ORDER)));
   assign pow     = SZ_W'(1) << k_ff;

   always_comb begin
      case (state_ff)
         A_SPLIT: hd_rd_ord = ord_m1;
         F_PUSH:  hd_rd_ord = k_ff;
         default: hd_rd_ord = i_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR:    if (cnt_ff == IDX_W'(ENTRIES - 1)) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_ALLOC) state_in = A_SIZE;
               else if (f_ok)               state_in = F_CHK;
               else                         state_in = S_DONE;
            end
         end
         A_SIZE: begin
            if (k_ff > pool_order)   state_in = S_DONE;
            else if (pow >= size_ff) state_in = A_SRCH;
         end
         A_SRCH: begin
            if (hd_rd_val != NIL)        state_in = A_RM;
            else if (i_ff == pool_order) state_in = S_DONE;
         end
         A_RM:     state_in = (rd_nxt != NIL) ? A_RM_FIX : A_SPLIT;
         A_RM_FIX: state_in = A_SPLIT;
         A_SPLIT: begin
            if (i_ff > k_ff) begin
               if (hd_rd_val != NIL) state_in = PUSH_FIX;
            end else begin
               state_in = S_DONE;
            end
         end
         PUSH_FIX: state_in = (op_ff == ACT_ALLOC) ? A_SPLIT : S_DONE;
         F_CHK:    state_in = (rd_tag != TAG_RESERVED) ? S_DONE : F_MERGE;
         F_MERGE:  state_in = (k_ff < pool_order) ? F_BUD : F_PUSH;
         F_BUD: begin
            if (rd_tag == TAG_FREE && rd_ord == k_ff)
               state_in = (rd_prv == NIL) ? F_RM_N : F_RM_P;
            else
               state_in = F_PUSH;
         end
         F_RM_P:   state_in = F_RM_N;
         F_RM_N:   state_in = (n_ff != NIL) ? F_RM_NF : F_UNU;
         F_RM_NF:  state_in = F_UNU;
         F_UNU:    state_in = F_MERGE;
         F_PUSH:   state_in = (hd_rd_val != NIL) ? PUSH_FIX : S_DONE;
         S_DONE:   if (res_ready) state_in = S_IDLE;
         default:  state_in = S_CLR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      op_in   = op_ff;
      size_in = size_ff;
      k_in    = k_ff;
      i_in    = i_ff;
      idx_in  = idx_ff;
      bud_in  = bud_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      p_in    = p_ff;
      n_in    = n_ff;
      res_in  = res_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      hd_wr_en  = 1'b0;
      hd_wr_ord = k_ff;
      hd_wr_val = NIL;
      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = (cnt_ff == '0) ? mk(TAG_FREE, pool_order, NIL, NIL)
                                     : mk(TAG_UNUSED, '0, NIL, NIL);
            cnt_in  = cnt_ff + IDX_W'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in   = action_type'(req_action);
               size_in = SZ_W'(req_request_bytes) + SZ_W'(HEADER_BYTES);
               k_in    = ORD_W'(GRAIN_ORDER);
               idx_in  = fidx;
               rd_en   = (req_action == ACT_FREE) && f_ok;
               rd_addr = fidx;
               res_in  = '{status: ST_IGNORED, offset: '0, order: '0};
            end
         end
         A_SIZE: begin
            if (k_ff > pool_order)
               res_in = '{status: ST_TOOBIG, offset: '0, order: '0};
            else if (pow >= size_ff)
               i_in = k_ff;
            else
               k_in = k_ff + ORD_W'(1);
         end
         A_SRCH: begin
            if (hd_rd_val != NIL) begin
               idx_in  = hd_rd_val[IDX_W-1:0];
               rd_en   = 1'b1;
               rd_addr = hd_rd_val[IDX_W-1:0];
            end else if (i_ff == pool_order) begin
               res_in = '{status: ST_NOMEM, offset: '0, order: '0};
            end else begin
               i_in = i_ff + ORD_W'(1);
            end
         end
         A_RM: begin
            hd_wr_en  = 1'b1;
            hd_wr_ord = i_ff;
            hd_wr_val = rd_nxt;
            n_in      = rd_nxt;
            rd_en     = (rd_nxt != NIL);
            rd_addr   = rd_nxt[IDX_W-1:0];
         end
         A_RM_FIX: begin
            wr_en   = 1'b1;
            wr_addr = n_ff[IDX_W-1:0];
            wr_data = {rd_data[WORD_W-1:LNK_W], NIL};
         end
         A_SPLIT: begin
            if (i_ff > k_ff) begin
               // upper half goes on the head of the next order down
               wr_en     = 1'b1;
               wr_addr   = split_b;
               wr_data   = mk(TAG_FREE, ord_m1, hd_rd_val, NIL);
               hd_wr_en  = 1'b1;
               hd_wr_ord = ord_m1;
               hd_wr_val = {1'b0, split_b};
               i_in      = ord_m1;
               pend_in   = split_b;
               n_in      = hd_rd_val;
               rd_en     = (hd_rd_val != NIL);
               rd_addr   = hd_rd_val[IDX_W-1:0];
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = mk(TAG_RESERVED, k_ff, NIL, NIL);
               res_in  = '{status: ST_OK, offset: off_c[OFF_W-1:0], order: k_ff};
            end
         end
         PUSH_FIX: begin
            wr_en   = 1'b1;
            wr_addr = n_ff[IDX_W-1:0];
            wr_data = {rd_data[WORD_W-1:LNK_W], 1'b0, pend_ff};
         end
         F_CHK: begin
            k_in = rd_ord;
         end
         F_MERGE: begin
            bud_in  = merge_b;
            rd_en   = (k_ff < pool_order);
            rd_addr = merge_b;
         end
         F_BUD: begin
            if (rd_tag == TAG_FREE && rd_ord == k_ff) begin
               p_in      = rd_prv;
               n_in      = rd_nxt;
               hd_wr_en  = (rd_prv == NIL);
               hd_wr_ord = k_ff;
               hd_wr_val = rd_nxt;
               rd_en     = (rd_prv != NIL);
               rd_addr   = rd_prv[IDX_W-1:0];
            end
         end
         F_RM_P: begin
            wr_en   = 1'b1;
            wr_addr = p_ff[IDX_W-1:0];
            wr_data = {rd_data[WORD_W-1 -: 2+ORD_W], n_ff, rd_data[LNK_W-1:0]};
         end
         F_RM_N: begin
            rd_en   = (n_ff != NIL);
            rd_addr = n_ff[IDX_W-1:0];
         end
         F_RM_NF: begin
            wr_en   = 1'b1;
            wr_addr = n_ff[IDX_W-1:0];
            wr_data = {rd_data[WORD_W-1:LNK_W], p_ff};
         end
         F_UNU: begin
            wr_en   = 1'b1;
            wr_addr = (bud_ff > idx_ff) ? bud_ff : idx_ff;
            wr_data = mk(TAG_UNUSED, '0, NIL, NIL);
            idx_in  = (bud_ff > idx_ff) ? idx_ff : bud_ff;
            k_in    = k_ff + ORD_W'(1);
         end
         F_PUSH: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = mk(TAG_FREE, k_ff, hd_rd_val, NIL);
            hd_wr_en  = 1'b1;
            hd_wr_ord = k_ff;
            hd_wr_val = {1'b0, idx_ff};
            pend_in   = idx_ff;
            n_in      = hd_rd_val;
            rd_en     = (hd_rd_val != NIL);
            rd_addr   = hd_rd_val[IDX_W-1:0];
            res_in    = '{status: ST_OK, offset: '0, order: k_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         state_ff <= S_CLR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      op_ff   <= op_in;
      size_ff <= size_in;
      k_ff    <= k_in;
      i_ff    <= i_in;
      idx_ff  <= idx_in;
      bud_ff  <= bud_in;
      pend_ff <= pend_in;
      p_ff    <= p_in;
      n_ff    <= n_in;
      res_ff  <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   bba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bba_heads #(
      .POOL_ORDER_MAX (POOL_ORDER_MAX)
   ) u_heads (
      .clock      (clock),
      .reset      (reset),
      .init       (cfg_wr),
      .init_order (cfg_order),
      .rd_order   (hd_rd_ord),
      .rd_value   (hd_rd_val),
      .wr_en      (hd_wr_en),
      .wr_order   (hd_wr_ord),
      .wr_value   (hd_wr_val)
   );

endmodule

>>> verif/buddy_block_allocator_test.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// Self-checking bench: random and directed allocate/free beats against an
// in-bench buddy predictor, over several pool sizes set via the CSR port.
// ----------------------------------------------------------------------------
module buddy_block_allocator_test;
   import bba_pkg::*;

   localparam int HDR       = 24;
   localparam int MAXO      = 20;
   localparam int SLOTS     = 1 << (MAXO - GRAIN_ORDER);
   localparam int CYCLE_CAP = 3000000;
   localparam int SETTLE    = 400;
   localparam logic [15:0] NIL = 16'hFFFF;
   localparam logic [1:0]  REG_POOL_ORDER = 2'd0;

   typedef struct {
      action_type       act;
      logic [REQ_W-1:0] nbytes;
      logic [OFF_W-1:0] uoff;
   } job_type;

   logic             clock, reset;
   logic             req_valid, req_stall, req_action;
   logic [REQ_W-1:0] req_request_bytes;
   logic [OFF_W-1:0] req_user_offset;
   logic             rsp_valid, rsp_stall;
   logic [1:0]       rsp_status;
   logic [OFF_W-1:0] rsp_granted_offset;
   logic [ORD_W-1:0] rsp_granted_order;
   logic             psel, penable, pwrite, pready;
   logic [1:0]       paddr;
   logic [31:0]      pwdata, prdata;

   buddy_block_allocator dut (.*);

   // predictor state, indexed by block start >> GRAIN_ORDER
   int unsigned      pool_ord;
   tag_type          tag_tbl   [SLOTS];
   logic [ORD_W-1:0] ord_tbl   [SLOTS];
   logic [15:0]      next_tbl  [SLOTS];
   logic [15:0]      prev_tbl  [SLOTS];
   logic [15:0]      head_tbl  [MAXO+1];

   job_type           job_q[$];      // beats waiting for the driver
   res_type           grant_q[$];    // predicted response beats, oldest first
   logic [OFF_W-1:0]  live_q[$];     // user offsets currently held
   int                fails = 0;
   int                beats_in = 0, beats_out = 0;
   int                st_count[4] = '{0, 0, 0, 0};
   int                cycles = 0;
   logic              req_taken;

   // ---------------------------------------------------------------------
   // Buddy predictor
   // ---------------------------------------------------------------------
   function automatic void pool_reset();
      for (int i = 0; i < SLOTS; i++) begin
         tag_tbl[i]  = TAG_UNUSED;
         ord_tbl[i]  = '0;
         next_tbl[i] = NIL;
         prev_tbl[i] = NIL;
      end
      for (int i = 0; i <= MAXO; i++) head_tbl[i] = NIL;
      tag_tbl[0]        = TAG_FREE;
      ord_tbl[0]        = pool_ord[ORD_W-1:0];
      head_tbl[pool_ord] = 16'd0;
   endfunction

   function automatic void push_free(logic [15:0] idx, int unsigned k);
      logic [15:0] h;
      h = head_tbl[k];
      tag_tbl[idx]  = TAG_FREE;
      ord_tbl[idx]  = k[ORD_W-1:0];
      prev_tbl[idx] = NIL;
      next_tbl[idx] = h;
      if (h != NIL) prev_tbl[h] = idx;
      head_tbl[k] = idx;
   endfunction

   function automatic void unlink(logic [15:0] idx);
      logic [15:0] p, n;
      p = prev_tbl[idx];
      n = next_tbl[idx];
      if (p == NIL) head_tbl[ord_tbl[idx]] = n;
      else next_tbl[p] = n;
      if (n != NIL) prev_tbl[n] = p;
      next_tbl[idx] = NIL;
      prev_tbl[idx] = NIL;
   endfunction

   function automatic res_type predict_alloc(logic [REQ_W-1:0] nbytes);
      res_type     r;
      longint      need;
      int unsigned k, i, o;
      logic [15:0] idx;
      r    = '{ST_OK, '0, '0};
      need = longint'(nbytes) + HDR;
      k    = GRAIN_ORDER;
      while ((longint'(1) << k) < need) k++;
      if (k > pool_ord) begin
         r.status = ST_TOOBIG;
         return r;
      end
      i = k;
      while (i <= pool_ord && head_tbl[i] == NIL) i++;
      if (i > pool_ord) begin
         r.status = ST_NOMEM;
         return r;
      end
      idx = head_tbl[i];
      unlink(idx);
      o = i;
      while (o > k) begin
         o--;
         push_free(idx ^ (16'd1 << (o - GRAIN_ORDER)), o);
      end
      ord_tbl[idx] = k[ORD_W-1:0];
      tag_tbl[idx] = TAG_RESERVED;
      r.offset = OFF_W'((int'(idx) << GRAIN_ORDER) + HDR);
      r.order  = k[ORD_W-1:0];
      return r;
   endfunction

   function automatic res_type predict_free(logic [OFF_W-1:0] uoff);
      res_type     r;
      int unsigned start, k;
      logic [15:0] idx, bud;
      r = '{ST_IGNORED, '0, '0};
      if (uoff < HDR) return r;
      start = uoff - HDR;
      if (start[GRAIN_ORDER-1:0] != 0 || start >= (1 << pool_ord)) return r;
      idx = 16'(start >> GRAIN_ORDER);
      if (tag_tbl[idx] != TAG_RESERVED) return r;
      k = ord_tbl[idx];
      while (k < pool_ord) begin
         bud = idx ^ (16'd1 << (k - GRAIN_ORDER));
         if (tag_tbl[bud] != TAG_FREE || ord_tbl[bud] != k) break;
         unlink(bud);
         if (bud < idx) begin
            tag_tbl[idx] = TAG_UNUSED;
            idx = bud;
         end else begin
            tag_tbl[bud] = TAG_UNUSED;
         end
         k++;
      end
      push_free(idx, k);
      r.status = ST_OK;
      r.order  = k[ORD_W-1:0];
      return r;
   endfunction

   // queue a beat, predict its response and track held blocks
   function automatic void issue(action_type act, logic [REQ_W-1:0] nbytes,
                                 logic [OFF_W-1:0] uoff);
      res_type r;
      job_q.push_back('{act, nbytes, uoff});
      if (act == ACT_ALLOC) begin
         r = predict_alloc(nbytes);
         if (r.status == ST_OK) live_q.push_back(r.offset);
      end else begin
         r = predict_free(uoff);
         if (r.status == ST_OK)
            foreach (live_q[i])
               if (live_q[i] == uoff) begin
                  live_q.delete(i);
                  break;
               end
      end
      grant_q.push_back(r);
   endfunction

   // ---------------------------------------------------------------------
   // Clock, cycle cap
   // ---------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("buddy_block_allocator_test failed");
         $finish;
      end
   end

   // steady window: neither side idles while it is open
   wire steady = (beats_in >= 350 && beats_in < 520);

   // ---------------------------------------------------------------------
   // Request driver: new payload only after the previous beat was taken
   // ---------------------------------------------------------------------
   always @(posedge clock) req_taken <= req_valid && !req_stall;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (job_q.size() > 0 && (steady || $urandom_range(0, 99) >= 27)) begin
            req_valid         <= 1'b1;
            req_action        <= job_q[0].act;
            req_request_bytes <= job_q[0].nbytes;
            req_user_offset   <= job_q[0].uoff;
            void'(job_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock)
      if (!reset && req_valid && !req_stall) beats_in <= beats_in + 1;

   // ---------------------------------------------------------------------
   // Response monitor
   // ---------------------------------------------------------------------
   always @(negedge clock)
      rsp_stall <= !steady && $urandom_range(0, 99) < 27;

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out <= beats_out + 1;
         st_count[rsp_status] <= st_count[rsp_status] + 1;
         if (grant_q.size() == 0) begin
            $error("response beat with nothing expected");
            fails <= fails + 1;
         end else begin
            want = grant_q.pop_front();
            if (rsp_status != want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fails <= fails + 1;
            end
            if (rsp_granted_offset != want.offset) begin
               $error("granted_offset: expected %0d, got %0d",
                      want.offset, rsp_granted_offset);
               fails <= fails + 1;
            end
            if (rsp_granted_order != want.order) begin
               $error("granted_order: expected %0d, got %0d",
                      want.order, rsp_granted_order);
               fails <= fails + 1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic drain();
      wait (job_q.size() == 0);
      @(posedge clock);
      while (req_valid || grant_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // APB write, setup then access phase; register lands at the access-phase edge
   task automatic csr_write(logic [1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // boundary beats for the current pool size
   task automatic edge_cases();
      int unsigned whole;
      whole = (1 << pool_ord) - HDR;
      issue(ACT_ALLOC, REQ_W'(whole), OFF_W'($urandom));      // whole pool
      issue(ACT_ALLOC, '0, '0);                                // exhausted
      issue(ACT_FREE, REQ_W'($urandom), OFF_W'(HDR));          // merges nothing
      issue(ACT_FREE, '0, OFF_W'(HDR));                        // double free
      issue(ACT_ALLOC, REQ_W'(whole + 1), '0);                 // one over pool
      if (pool_ord < MAXO)                                     // past pool end
         issue(ACT_FREE, '0, OFF_W'((1 << pool_ord) + HDR));
   endtask

   task automatic random_beats(int n);
      int unsigned e, pick, cap;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         cap  = (pool_ord < 12) ? pool_ord : 12;
         if (pick < 50) begin
            // mostly small, now and then large or oversized
            e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAXO + 1)
                                            : $urandom_range(0, cap);
            issue(ACT_ALLOC, REQ_W'($urandom_range(0, (1 << e) - 1) +
                                    ($urandom_range(0, 7) == 0 ? (1 << e) - HDR : 0)),
                  OFF_W'($urandom));
         end else if (pick < 88 && live_q.size() > 0) begin
            issue(ACT_FREE, REQ_W'($urandom),
                  live_q[$urandom_range(0, live_q.size() - 1)]);
         end else if (pick < 94) begin
            issue(ACT_FREE, REQ_W'($urandom), OFF_W'($urandom));
         end else begin
            // plausible-looking offset that is likely not held
            issue(ACT_FREE, REQ_W'($urandom),
                  OFF_W'(($urandom_range(0, (1 << (pool_ord - GRAIN_ORDER)) - 1)
                          << GRAIN_ORDER) + HDR));
         end
      end
   endtask

   task automatic new_pool(logic [4:0] value);
      csr_write(REG_POOL_ORDER, {27'd0, value});
      pool_ord = (value < POOL_ORDER_MIN) ? POOL_ORDER_MIN :
                 (value > MAXO) ? MAXO : value;
      pool_reset();
      live_q.delete();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_action = ACT_ALLOC;
      req_request_bytes = '0; req_user_offset = '0;
      rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      pool_ord = MAXO;
      pool_reset();
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: sizes, rejects and a split/merge round trip at full pool
      issue(ACT_ALLOC, '0, 20'hFFFFF);                 // smallest block
      issue(ACT_ALLOC, 21'd8, '0);                     // exactly one grain
      issue(ACT_ALLOC, 21'd9, '0);                     // just over a grain
      issue(ACT_ALLOC, 21'h100000, '0);                // top bit of the field only
      issue(ACT_ALLOC, 21'd1000, '0);
      issue(ACT_FREE, 21'h1FFFFF, '0);                 // below header
      issue(ACT_FREE, '0, 20'd23);
      issue(ACT_FREE, '0, 20'd25);                     // not grain aligned
      issue(ACT_FREE, '0, 20'hFFFFF);
      issue(ACT_FREE, '0, OFF_W'(HDR + 32 * 500));     // never allocated
      issue(ACT_FREE, '0, OFF_W'(HDR + 32));           // second grain
      issue(ACT_FREE, '0, OFF_W'(HDR + 32));           // double free
      issue(ACT_FREE, '0, OFF_W'(HDR));                // merges upward
      issue(ACT_FREE, '0, OFF_W'(HDR + 1024));
      issue(ACT_ALLOC, 21'd1048552, '0);               // whole pool, no memory
      issue(ACT_ALLOC, 21'd1048553, '0);               // one past, too big
      issue(ACT_ALLOC, '0, '0);                        // smallest block, from a split
      issue(ACT_FREE, '0, OFF_W'(HDR));
      random_beats(330);
      drain();                                         // sender holds off

      new_pool(5'd3);                                  // saturates to min
      edge_cases();
      random_beats(120);
      drain();

      new_pool(5'd9);
      edge_cases();
      random_beats(200);
      drain();

      new_pool(5'd31);                                 // saturates to max
      edge_cases();
      random_beats(230);
      drain();

      new_pool(5'd12);
      edge_cases();
      random_beats(130);
      drain();

      $display("run covered %0d request beats over pool orders 20, 6, 9, 20, 12",
               beats_in);
      $display("responses: %0d ok, %0d no-memory, %0d too-large, %0d ignored frees",
               st_count[ST_OK], st_count[ST_NOMEM], st_count[ST_TOOBIG],
               st_count[ST_IGNORED]);
      if (fails == 0 && grant_q.size() == 0)
         $display("buddy_block_allocator_test passed");
      else
         $display("buddy_block_allocator_test failed");
      $finish;
   end

endmodule

>>> buddy_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_heads.sv
hw/rtl/bba_core.sv
hw/rtl/buddy_block_allocator.sv
verif/buddy_block_allocator_test.sv
